// ----- design/u2cp_pkg.sv -----
package u2cp_pkg;

  // Widths of the byte stream and of a decoded code point.
  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  // Lead byte classification masks and patterns.
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;

  // Continuation bytes still expected after each lead byte kind.
  localparam logic [PendW-1:0] PendNone = 2'd0;
  localparam logic [PendW-1:0] PendTwo  = 2'd1;
  localparam logic [PendW-1:0] PendThree = 2'd2;
  localparam logic [PendW-1:0] PendFour = 2'd3;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [PendW-1:0] pending;
    logic [CpW-1:0]   partial;
  } dec_state_t;

  // One result transaction.
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           has_char;
    logic           end_of_text;
  } dec_result_t;

endpackage

// ----- design/utf8_to_codepoint_decoder.sv -----
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   in_byte_i, last_byte_i
// out      output     out_valid_o/out_ready_i code_point_o, has_char_o, end_of_text_o
//
// One byte per cycle sustained while the result drains: the decode step sits between
// the input register and the result register, so a new byte can enter every cycle
// unless the result stalls. out_valid_o rises once a decoded byte is loaded into the result
// register; bytes that complete no code point and are not final produce no transaction.
// Reset clears the valid flags and the decoder state (no sequence open).
// A stalled result holds the input register; one byte can still enter, then in_ready_o drops.
module utf8_to_codepoint_decoder
  import u2cp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CpW-1:0]   code_point_o,
  output logic             has_char_o,
  output logic             end_of_text_o
);

  logic             byte_vld_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  dec_state_t       state_q, state_d;
  dec_result_t      res_q, res_d;
  logic             res_vld_q;
  logic             emit;
  logic             step_go;

  // The decode step advances when a byte is held and the result register is free or draining.
  assign step_go    = byte_vld_q & (~res_vld_q | out_ready_i);
  assign in_ready_o = ~byte_vld_q | step_go;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= last_byte_i;
    end
  end

  // Combinational decode of the registered byte.
  u2cp_step u_step (
    .state_i     (state_q),
    .in_byte_i   (byte_q),
    .last_byte_i (last_q),
    .state_o     (state_d),
    .result_o    (res_d),
    .emit_o      (emit)
  );

  // Decoder state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (step_go) begin
        state_q <= state_d;
      end
      if (step_go) begin
        res_vld_q <= emit;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = res_vld_q;
  assign code_point_o  = res_q.code_point;
  assign has_char_o    = res_q.has_char;
  assign end_of_text_o = res_q.end_of_text;

endmodule

// ----- design/u2cp_step.sv -----
module u2cp_step
  import u2cp_pkg::*;
(
  input  dec_state_t        state_i,
  input  logic [ByteW-1:0]  in_byte_i,
  input  logic              last_byte_i,
  output dec_state_t        state_o,
  output dec_result_t       result_o,
  output logic              emit_o
);

  logic [CpW-1:0]   shifted;
  logic [PendW-1:0] pend_dec;
  logic             have;
  logic [CpW-1:0]   cp;
  dec_state_t       nxt;

  // Partial value with the low six bits of a continuation byte appended.
  assign shifted  = {state_i.partial[CpW-7:0], in_byte_i[5:0]};
  assign pend_dec = state_i.pending - PendTwo;

  // Classify the byte against the open sequence, if any.
  always_comb begin
    have = 1'b0;
    cp   = '0;
    nxt  = state_i;
    priority if (state_i.pending != PendNone) begin
      nxt.pending = pend_dec;
      if (pend_dec == PendNone) begin
        have        = 1'b1;
        cp          = shifted;
        nxt.partial = '0;
      end else begin
        nxt.partial = shifted;
      end
    end else if (!in_byte_i[ByteW-1]) begin
      have = 1'b1;
      cp   = CpW'(in_byte_i);
    end else if ((in_byte_i & Lead2Mask) == Lead2Pat) begin
      nxt.partial = CpW'(in_byte_i[4:0]);
      nxt.pending = PendTwo;
    end else if ((in_byte_i & Lead3Mask) == Lead3Pat) begin
      nxt.partial = CpW'(in_byte_i[3:0]);
      nxt.pending = PendThree;
    end else if ((in_byte_i & Lead4Mask) == Lead4Pat) begin
      nxt.partial = CpW'(in_byte_i[2:0]);
      nxt.pending = PendFour;
    end else begin
      // Stray continuation or invalid lead byte: skipped.
      nxt = state_i;
    end

    // The final byte of a text drops any open sequence.
    if (last_byte_i) begin
      nxt.pending = PendNone;
      nxt.partial = '0;
    end
  end

  assign state_o              = nxt;
  assign result_o.code_point  = cp;
  assign result_o.has_char    = have;
  assign result_o.end_of_text = last_byte_i;
  assign emit_o               = have | last_byte_i;

endmodule
